FILE: rtl/mla_pkg.sv
// ---------------------------------------------------------------------------
// mla_pkg
// Shared types and constants of the multiclass linear argmax classifier.
// ---------------------------------------------------------------------------
package mla_pkg;

  localparam int CLS_W   = 4;   // class_index field
  localparam int FEAT_W  = 10;  // feature_index field
  localparam int VAL_W   = 16;  // signed Q8.8
  localparam int LBL_W   = 5;   // labels
  localparam int CNT_W   = 32;  // running counters
  localparam int CC_W    = 5;   // class_count register
  localparam int FC_W    = 11;  // feature_count register
  localparam int PROD_W  = 32;  // Q16.16 product
  localparam int SCORE_W = 40;  // Q24.16 score
  localparam int ADDR_W  = 3;   // config byte address

  // config register index (byte address bit 2)
  localparam logic CFG_IDX_CLASS_COUNT   = 1'b0;
  localparam logic CFG_IDX_FEATURE_COUNT = 1'b1;

  typedef enum logic {
    OP_WEIGHT  = 1'b0,
    OP_FEATURE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_ARG,
    ST_DONE
  } state_t;

  // one decoded command between front and back
  typedef struct packed {
    op_t                      op;
    logic                     use_feat;  // element contributes to the scores
    logic [CLS_W-1:0]         cls;
    logic [FEAT_W-1:0]        feat;
    logic signed [VAL_W-1:0]  val;
    logic                     last;
    logic [LBL_W-1:0]         truth;
  } cmd_entry_t;

endpackage

FILE: rtl/mla_front.sv
// ---------------------------------------------------------------------------
// mla_front
// Accepts input transfers, drops commands with no effect, queues the rest.
// ---------------------------------------------------------------------------
module mla_front import mla_pkg::*; #(
  parameter int NUM_CLASSES  = 16,
  parameter int NUM_FEATURES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [CLS_W-1:0]        in_class_index,
  input  logic [FEAT_W-1:0]       in_feature_index,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_element,
  input  logic [LBL_W-1:0]        in_true_label,
  input  logic [FC_W-1:0]         feature_count,
  output logic                    q_valid,
  output cmd_entry_t              q_entry,
  input  logic                    q_pop
);

  cmd_entry_t q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  logic       accept, keep, push;
  logic       feat_ok, cls_ok, in_feat_range;
  cmd_entry_t entry;

  assign in_stall = (count_r == 2'd2);
  assign accept   = in_valid && !in_stall;

  assign cls_ok        = ({28'd0, in_class_index} < NUM_CLASSES);
  assign feat_ok       = ({22'd0, in_feature_index} < NUM_FEATURES);
  assign in_feat_range = feat_ok && ({1'b0, in_feature_index} < feature_count);

  always_comb begin
    entry          = '0;
    entry.op       = op_t'(in_cmd);
    entry.cls      = in_class_index;
    entry.feat     = in_feature_index;
    entry.val      = in_value;
    entry.last     = in_last_element;
    entry.truth    = in_true_label;
    entry.use_feat = in_feat_range;
    if (entry.op == OP_WEIGHT) begin
      keep = cls_ok && feat_ok;
    end else begin
      keep = in_feat_range || in_last_element;
    end
  end

  assign push    = accept && keep;
  assign q_valid = (count_r != 2'd0);
  assign q_entry = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: rtl/mla_back.sv
// ---------------------------------------------------------------------------
// mla_back
// Weight memory, per-class multiply-accumulate, argmax and result register.
// ---------------------------------------------------------------------------
module mla_back import mla_pkg::*; #(
  parameter int NUM_CLASSES  = 16,
  parameter int NUM_FEATURES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CC_W-1:0]    class_count,
  input  logic               q_valid,
  input  cmd_entry_t         q_entry,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LBL_W-1:0]   out_predicted_label,
  output logic               out_is_correct,
  output logic [CNT_W-1:0]   out_correct_count,
  output logic [CNT_W-1:0]   out_samples_seen
);

  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int DEPTH = NUM_CLASSES * NUM_FEATURES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t state_r, state_nxt;

  logic signed [VAL_W-1:0]   weight_mem [DEPTH];
  logic signed [VAL_W-1:0]   rd_data_r;
  logic signed [SCORE_W-1:0] score_r [NUM_CLASSES];

  logic [CW-1:0]           cnt_r, rd_c_r, prod_c_r, best_r, nlast, sidx;
  logic [FEAT_W-1:0]       cur_feat_r;
  logic signed [VAL_W-1:0] cur_val_r;
  logic                    last_r;
  logic [LBL_W-1:0]        truth_r;
  logic                    rd_v_r, prod_v_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SCORE_W-1:0] best_s_r, sc;
  logic signed [SCORE_W:0]   sum;
  logic signed [SCORE_W-1:0] sat_sum;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic                    wr_en, out_free, load_out, cnt_end, correct;
  logic [CW:0]             lbl;

  logic                    out_valid_r, out_correct_r;
  logic [LBL_W-1:0]        out_label_r;
  logic [CNT_W-1:0]        correct_total_r, sample_total_r;

  // last active class index: zero counts as one, clamp at NUM_CLASSES
  always_comb begin
    if (class_count == '0) begin
      nlast = '0;
    end else if ({23'd0, class_count} > NUM_CLASSES) begin
      nlast = CW'(NUM_CLASSES - 1);
    end else begin
      nlast = CW'(class_count - 1'b1);
    end
  end

  assign cnt_end  = (cnt_r == nlast);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.op == OP_FEATURE) begin
            state_nxt = q_entry.use_feat ? ST_MAC : ST_ARG;
          end
        end
      end
      ST_MAC: begin
        if (cnt_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) state_nxt = last_r ? ST_ARG : ST_IDLE;
      end
      ST_ARG: begin
        if (cnt_end) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // weight memory: one write and one read per cycle
  assign wr_en   = q_pop && (q_entry.op == OP_WEIGHT);
  assign wr_addr = AW'(AW'(q_entry.cls) * AW'(NUM_FEATURES) + AW'(q_entry.feat));
  assign rd_addr = AW'(AW'(cnt_r) * AW'(NUM_FEATURES) + AW'(cur_feat_r));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      weight_mem[wr_addr] <= q_entry.val;
    end
    rd_data_r <= weight_mem[rd_addr];
  end

  // single score read port, shared by accumulate and argmax
  assign sidx = (state_r == ST_ARG) ? cnt_r : prod_c_r;
  assign sc   = score_r[sidx];
  assign sum  = {sc[SCORE_W-1], sc} + (SCORE_W+1)'(prod_r);
  always_comb begin
    if (sum[SCORE_W] != sum[SCORE_W-1]) begin
      sat_sum = sum[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sat_sum = sum[SCORE_W-1:0];
    end
  end

  assign lbl     = {1'b0, best_r} + 1'b1;
  assign correct = (32'(lbl) == 32'(truth_r));

  always_ff @(posedge clk) begin
    prod_r   <= rd_data_r * cur_val_r;
    rd_c_r   <= cnt_r;
    prod_c_r <= rd_c_r;
    if (q_pop) begin
      cur_feat_r <= q_entry.feat;
      cur_val_r  <= q_entry.val;
      last_r     <= q_entry.last;
      truth_r    <= q_entry.truth;
    end
    if (state_r == ST_ARG && (cnt_r == '0 || sc > best_s_r)) begin
      best_r   <= cnt_r;
      best_s_r <= sc;
    end
    if (load_out) begin
      out_label_r   <= LBL_W'(lbl);
      out_correct_r <= correct;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r           <= '0;
      rd_v_r          <= 1'b0;
      prod_v_r        <= 1'b0;
      out_valid_r     <= 1'b0;
      correct_total_r <= '0;
      sample_total_r  <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) score_r[i] <= '0;
    end else begin
      rd_v_r   <= (state_r == ST_MAC);
      prod_v_r <= rd_v_r;
      if (q_pop || state_r == ST_DRAIN) begin
        cnt_r <= '0;
      end else if ((state_r == ST_MAC || state_r == ST_ARG) && !cnt_end) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (prod_v_r) begin
        score_r[prod_c_r] <= sat_sum;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        if (sample_total_r != '1) sample_total_r <= sample_total_r + 1'b1;
        if (correct && correct_total_r != '1) correct_total_r <= correct_total_r + 1'b1;
        for (int i = 0; i < NUM_CLASSES; i++) score_r[i] <= '0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_label = out_label_r;
  assign out_is_correct      = out_correct_r;
  assign out_correct_count   = correct_total_r;
  assign out_samples_seen    = sample_total_r;

  a_idle_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rd_v_r && !prod_v_r))
    else $error("memory read still in flight while idle");

  a_read_to_product: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |=> prod_v_r)
    else $error("weight read did not reach the multiplier");

  a_pop_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && q_valid))
    else $error("queue popped outside idle or while empty");

  a_counts_order: assert property (@(posedge clk) disable iff (!rst_n)
    correct_total_r <= sample_total_r)
    else $error("correct count exceeds sample count");

endmodule

FILE: rtl/multiclass_linear_argmax.sv
// ---------------------------------------------------------------------------
// multiclass_linear_argmax
// Multiclass linear classifier: per-class dot products over a sparse
// feature stream, argmax decision and running accuracy counters.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | input     | in_valid/in_stall   | cmd, class, feature, value, last, label
//  out_     | output    | out_valid/out_stall | predicted label, correct, counts
//  cfg (APB)| input     | psel/penable/pready | class_count @0x0, feature_count @0x4
//
// Sequence: a weight write goes straight into the weight memory. A feature element
//   steps through the active classes: the single weight memory read port gives one
//   class weight per cycle. A last element adds an argmax scan over the score
//   registers, then loads the result once the result register is free.
// Reset: synchronous, active low; scores and counters clear, weights do not.
// Stalls: a two-entry queue decouples input from the back end; the result
//   register holds while out_stall is high and the back end waits for it.
// ---------------------------------------------------------------------------
module multiclass_linear_argmax import mla_pkg::*; #(
  parameter int NUM_CLASSES  = 16,
  parameter int NUM_FEATURES = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [CLS_W-1:0]        in_class_index,
  input  logic [FEAT_W-1:0]       in_feature_index,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_element,
  input  logic [LBL_W-1:0]        in_true_label,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LBL_W-1:0]        out_predicted_label,
  output logic                    out_is_correct,
  output logic [CNT_W-1:0]        out_correct_count,
  output logic [CNT_W-1:0]        out_samples_seen,
  // configuration
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic [CC_W-1:0] class_count_r;
  logic [FC_W-1:0] feature_count_r;
  logic            cfg_wr;
  logic            q_valid, q_pop;
  cmd_entry_t      q_entry;

  // registers are decoded by address bit 2; low bits are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      class_count_r   <= CC_W'(16);
      feature_count_r <= FC_W'(1024);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        CFG_IDX_CLASS_COUNT:   class_count_r   <= pwdata[CC_W-1:0];
        CFG_IDX_FEATURE_COUNT: feature_count_r <= pwdata[FC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_IDX_CLASS_COUNT:   prdata = {{(32-CC_W){1'b0}}, class_count_r};
      CFG_IDX_FEATURE_COUNT: prdata = {{(32-FC_W){1'b0}}, feature_count_r};
      default:               prdata = '0;
    endcase
  end

  // front: accept, drop no-op commands, queue
  mla_front #(
    .NUM_CLASSES  (NUM_CLASSES),
    .NUM_FEATURES (NUM_FEATURES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_class_index   (in_class_index),
    .in_feature_index (in_feature_index),
    .in_value         (in_value),
    .in_last_element  (in_last_element),
    .in_true_label    (in_true_label),
    .feature_count    (feature_count_r),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop)
  );

  // back: weights, MAC per class, argmax, counters, result register
  mla_back #(
    .NUM_CLASSES  (NUM_CLASSES),
    .NUM_FEATURES (NUM_FEATURES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .class_count         (class_count_r),
    .q_valid             (q_valid),
    .q_entry             (q_entry),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_label (out_predicted_label),
    .out_is_correct      (out_is_correct),
    .out_correct_count   (out_correct_count),
    .out_samples_seen    (out_samples_seen)
  );

endmodule
